// ===== rtl/sit_pkg.sv =====
// Package for the sequence id slot table.
// Field widths, codes, state type, result struct and the status helper.
// No dependencies.
package sit_pkg;

    localparam int SLOTS_DEF     = 16;
    localparam int ID_BITS_DEF   = 32;
    localparam int DATA_BITS_DEF = 32;
    localparam int MAX_CAP       = 16;

    localparam int OP_W    = 2;
    localparam int ID_W    = 32;
    localparam int DATA_W  = 32;
    localparam int MASK_W  = 16;
    localparam int SLOT_W  = 4;
    localparam int CNT_W   = 5;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [CNT_W-1:0] SLOTS_CFG_RST = 5'd16;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_CLEAN  = 2'd1,
        OP_LIST   = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STATUS,
        ST_SCAN,
        ST_INSERT,
        ST_CLEAN,
        ST_LIST_FIND,
        ST_LIST_EMIT
    } state_t;

    typedef struct packed {
        logic              accepted;
        logic [ID_W-1:0]   seq_id_out;
        logic [DATA_W-1:0] payload_out;
        logic [SLOT_W-1:0] slot;
        logic              entry_valid;
        logic              last;
        logic [CNT_W-1:0]  count;
        logic              full_res;
        logic              empty_res;
    } rsp_t;

    function automatic rsp_t make_status(input logic [CNT_W-1:0] cnt,
                                         input logic [CNT_W-1:0] cap);
        rsp_t r;
        r             = '0;
        r.last        = 1'b1;
        r.count       = cnt;
        r.full_res    = (cnt >= cap);
        r.empty_res   = (cnt == '0);
        return r;
    endfunction

endpackage

// ===== rtl/sit_if.sv =====
// Request and result channel interfaces for the slot table.
// Depends on sit_pkg for field widths.
interface sit_req_if;
    logic                          valid;
    logic                          ready;
    logic [sit_pkg::OP_W-1:0]      operation;
    logic [sit_pkg::ID_W-1:0]      seq_id;
    logic [sit_pkg::DATA_W-1:0]    payload;
    logic [sit_pkg::MASK_W-1:0]    delete_mask;

    modport source (output valid, operation, seq_id, payload, delete_mask, input ready);
    modport sink   (input valid, operation, seq_id, payload, delete_mask, output ready);
endinterface

interface sit_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          accepted;
    logic [sit_pkg::ID_W-1:0]      seq_id_out;
    logic [sit_pkg::DATA_W-1:0]    payload_out;
    logic [sit_pkg::SLOT_W-1:0]    slot;
    logic                          entry_valid;
    logic                          last;
    logic [sit_pkg::CNT_W-1:0]     count;
    logic                          full_res;
    logic                          empty_res;

    modport source (output valid, accepted, seq_id_out, payload_out, slot, entry_valid,
                    last, count, full_res, empty_res, input ready);
    modport sink   (input valid, accepted, seq_id_out, payload_out, slot, entry_valid,
                    last, count, full_res, empty_res, output ready);
endinterface

// ===== rtl/sequence_id_slot_table.sv =====
// Sequence id slot table: top level, control sequencer and id/data memories.
// Depends on sit_pkg and the channel interfaces in sit_if.sv.
//
//   channel   dir   kind       role
//   req       in    valid/rdy  operation, seq_id, payload, delete_mask
//   rsp       out   valid/rdy  one result per item, one per entry for list
//   apb       in    APB        slots_in_use at byte address 0
//
// Steps: auto-id insert and full-table refuse go straight to a result; explicit-id
// insert scans first (one id memory read per slot); clean walks all active slots.
// Occupancy lives in per-slot valid flops cleared by reset; no clearing pass.
// A result register decouples rsp; a stalled rsp holds the sequencer in place.
module sequence_id_slot_table #(
    parameter int SLOTS     = sit_pkg::SLOTS_DEF,
    parameter int ID_BITS   = sit_pkg::ID_BITS_DEF,
    parameter int DATA_BITS = sit_pkg::DATA_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sit_pkg::PADDR_W-1:0]   paddr,
    input  logic [sit_pkg::PDATA_W-1:0]   pwdata,
    output logic [sit_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    sit_req_if.sink                       req,
    sit_rsp_if.source                     rsp
);

    localparam int DEPTH = (SLOTS < sit_pkg::MAX_CAP) ? SLOTS : sit_pkg::MAX_CAP;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [sit_pkg::CNT_W-1:0] CAP_MAX = sit_pkg::CNT_W'(DEPTH);

    // configuration
    logic [sit_pkg::CNT_W-1:0] slots_cfg_reg;
    logic                      cfg_wr;
    logic [sit_pkg::CNT_W-1:0] cap;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? '0 : sit_pkg::PDATA_W'(slots_cfg_reg);

    always_comb
    begin
        cap = (slots_cfg_reg == '0) ? sit_pkg::CNT_W'(1) : slots_cfg_reg;
        if (cap > CAP_MAX)
        begin
            cap = CAP_MAX;
        end
    end

    // state
    sit_pkg::state_t           state_reg, state_next;
    logic [DEPTH-1:0]          valid_reg, valid_next;
    logic [sit_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [ID_BITS-1:0]        auto_reg, auto_next;
    logic [sit_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic                      cmp_vld_reg, cmp_vld_next;
    logic                      out_vld_reg, out_vld_next;
    logic [AW-1:0]             cmp_slot_reg, cmp_slot_next;
    logic [AW-1:0]             list_slot_reg, list_slot_next;
    sit_pkg::rsp_t             rsp_reg, rsp_next;
    logic [ID_BITS-1:0]        id_reg;
    logic [DATA_BITS-1:0]      data_reg;
    logic [sit_pkg::MASK_W-1:0] mask_reg;

    // memories
    logic [ID_BITS-1:0]   ids_mem  [DEPTH];
    logic [DATA_BITS-1:0] data_mem [DEPTH];
    logic [ID_BITS-1:0]   rd_id_reg;
    logic [DATA_BITS-1:0] rd_data_reg;
    logic                 wr_en, rd_en;
    logic [AW-1:0]        ra;

    // combinational helpers
    logic                 accept, out_free;
    logic [ID_BITS-1:0]   id_in, auto_inc, id_load;
    logic [DEPTH-1:0]     active, occ_act, cand, above;
    logic                 free_found, cand_found, hit, list_last;
    logic [AW-1:0]        free_idx, cand_idx;
    logic [63:0]          id_wide_out, rd_id_wide, rd_data_wide;

    assign req.ready = (state_reg == sit_pkg::ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_vld_reg || rsp.ready;

    assign id_in    = ID_BITS'(req.seq_id);
    assign auto_inc = ((auto_reg + ID_BITS'(1)) == '0) ? ID_BITS'(1)
                                                        : auto_reg + ID_BITS'(1);
    assign id_load  = (id_in == '0) ? auto_inc : id_in;

    assign id_wide_out  = 64'(id_reg);
    assign rd_id_wide   = 64'(rd_id_reg);
    assign rd_data_wide = 64'(rd_data_reg);

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        cand_found = 1'b0;
        cand_idx   = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            active[i]  = (sit_pkg::CNT_W'(i) < cap);
            occ_act[i] = active[i] && valid_reg[i];
            cand[i]    = occ_act[i] && (sit_pkg::CNT_W'(i) >= idx_reg);
            above[i]   = occ_act[i] && (sit_pkg::CNT_W'(i) > sit_pkg::CNT_W'(list_slot_reg));
            if (active[i] && !valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = AW'(i);
            end
            if (cand[i])
            begin
                cand_found = 1'b1;
                cand_idx   = AW'(i);
            end
        end
    end

    assign list_last = (above == '0);
    assign hit = cmp_vld_reg && valid_reg[cmp_slot_reg] && (rd_id_reg == id_reg);

    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        cnt_next       = cnt_reg;
        auto_next      = auto_reg;
        idx_next       = idx_reg;
        cmp_vld_next   = 1'b0;
        cmp_slot_next  = cmp_slot_reg;
        list_slot_next = list_slot_reg;
        rsp_next       = rsp_reg;
        out_vld_next   = out_vld_reg && !rsp.ready;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        ra             = '0;

        unique case (state_reg)
            sit_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    idx_next = '0;
                    case (sit_pkg::op_t'(req.operation))
                        sit_pkg::OP_INSERT:
                        begin
                            if (cnt_reg >= cap)
                            begin
                                state_next = sit_pkg::ST_STATUS;
                            end
                            else if (id_in == '0)
                            begin
                                auto_next  = auto_inc;
                                state_next = sit_pkg::ST_INSERT;
                            end
                            else
                            begin
                                state_next = sit_pkg::ST_SCAN;
                            end
                        end
                        sit_pkg::OP_CLEAN:
                        begin
                            state_next = sit_pkg::ST_CLEAN;
                        end
                        sit_pkg::OP_LIST:
                        begin
                            state_next = (occ_act == '0) ? sit_pkg::ST_STATUS
                                                         : sit_pkg::ST_LIST_FIND;
                        end
                        default:
                        begin
                            state_next = sit_pkg::ST_STATUS;
                        end
                    endcase
                end
            end

            sit_pkg::ST_STATUS:
            begin
                if (out_free)
                begin
                    rsp_next     = sit_pkg::make_status(cnt_reg, cap);
                    out_vld_next = 1'b1;
                    state_next   = sit_pkg::ST_IDLE;
                end
            end

            // one id read per cycle, compare in the next cycle
            sit_pkg::ST_SCAN:
            begin
                if (hit)
                begin
                    state_next = sit_pkg::ST_STATUS;
                end
                else if (idx_reg < cap)
                begin
                    rd_en         = 1'b1;
                    ra            = idx_reg[AW-1:0];
                    cmp_slot_next = idx_reg[AW-1:0];
                    cmp_vld_next  = 1'b1;
                    idx_next      = idx_reg + sit_pkg::CNT_W'(1);
                end
                else
                begin
                    state_next = sit_pkg::ST_INSERT;
                end
            end

            sit_pkg::ST_INSERT:
            begin
                if (out_free)
                begin
                    out_vld_next = 1'b1;
                    state_next   = sit_pkg::ST_IDLE;
                    if (free_found)
                    begin
                        wr_en                = 1'b1;
                        valid_next[free_idx] = 1'b1;
                        cnt_next             = cnt_reg + sit_pkg::CNT_W'(1);
                        rsp_next             = sit_pkg::make_status(cnt_next, cap);
                        rsp_next.accepted    = 1'b1;
                        rsp_next.seq_id_out  = id_wide_out[sit_pkg::ID_W-1:0];
                        rsp_next.slot        = sit_pkg::SLOT_W'(free_idx);
                    end
                    else
                    begin
                        rsp_next = sit_pkg::make_status(cnt_reg, cap);
                    end
                end
            end

            sit_pkg::ST_CLEAN:
            begin
                if (idx_reg < cap)
                begin
                    if (valid_reg[idx_reg[AW-1:0]] && mask_reg[idx_reg[3:0]])
                    begin
                        valid_next[idx_reg[AW-1:0]] = 1'b0;
                        cnt_next = cnt_reg - sit_pkg::CNT_W'(1);
                    end
                    idx_next = idx_reg + sit_pkg::CNT_W'(1);
                end
                else
                begin
                    state_next = sit_pkg::ST_STATUS;
                end
            end

            sit_pkg::ST_LIST_FIND:
            begin
                if (cand_found)
                begin
                    rd_en          = 1'b1;
                    ra             = cand_idx;
                    list_slot_next = cand_idx;
                    state_next     = sit_pkg::ST_LIST_EMIT;
                end
                else
                begin
                    state_next = sit_pkg::ST_IDLE;
                end
            end

            sit_pkg::ST_LIST_EMIT:
            begin
                if (out_free)
                begin
                    rsp_next             = sit_pkg::make_status(cnt_reg, cap);
                    rsp_next.entry_valid = 1'b1;
                    rsp_next.seq_id_out  = rd_id_wide[sit_pkg::ID_W-1:0];
                    rsp_next.payload_out = rd_data_wide[sit_pkg::DATA_W-1:0];
                    rsp_next.slot        = sit_pkg::SLOT_W'(list_slot_reg);
                    rsp_next.last        = list_last;
                    out_vld_next         = 1'b1;
                    if (list_last)
                    begin
                        state_next = sit_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = sit_pkg::CNT_W'(list_slot_reg) + sit_pkg::CNT_W'(1);
                        state_next = sit_pkg::ST_LIST_FIND;
                    end
                end
            end

            default:
            begin
                state_next = sit_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sit_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_cfg_reg <= sit_pkg::SLOTS_CFG_RST;
            valid_reg     <= '0;
            cnt_reg       <= '0;
            auto_reg      <= '0;
            idx_reg       <= '0;
            cmp_vld_reg   <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                slots_cfg_reg <= pwdata[sit_pkg::CNT_W-1:0];
            end
            valid_reg   <= valid_next;
            cnt_reg     <= cnt_next;
            auto_reg    <= auto_next;
            idx_reg     <= idx_next;
            cmp_vld_reg <= cmp_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            id_reg   <= id_load;
            data_reg <= DATA_BITS'(req.payload);
            mask_reg <= req.delete_mask;
        end
        cmp_slot_reg  <= cmp_slot_next;
        list_slot_reg <= list_slot_next;
        rsp_reg       <= rsp_next;
    end

    // sequential items only: a write never overlaps a read of a later item
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ids_mem[free_idx]  <= id_reg;
            data_mem[free_idx] <= data_reg;
        end
        if (rd_en)
        begin
            rd_id_reg   <= ids_mem[ra];
            rd_data_reg <= data_mem[ra];
        end
    end

    assign rsp.valid       = out_vld_reg;
    assign rsp.accepted    = rsp_reg.accepted;
    assign rsp.seq_id_out  = rsp_reg.seq_id_out;
    assign rsp.payload_out = rsp_reg.payload_out;
    assign rsp.slot        = rsp_reg.slot;
    assign rsp.entry_valid = rsp_reg.entry_valid;
    assign rsp.last        = rsp_reg.last;
    assign rsp.count       = rsp_reg.count;
    assign rsp.full_res    = rsp_reg.full_res;
    assign rsp.empty_res   = rsp_reg.empty_res;

    a_cnt_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == sit_pkg::CNT_W'($countones(valid_reg)))
        else $error("occupied count out of step with valid bits");

    a_write_to_free: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !valid_reg[free_idx] && (id_reg != '0))
        else $error("insert onto occupied slot or with zero id");

    a_list_slot_occupied: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sit_pkg::ST_LIST_EMIT) |-> valid_reg[list_slot_reg])
        else $error("listing a free slot");

    a_one_result_per_load: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !rsp.ready) |=> out_vld_reg && $stable(rsp_reg))
        else $error("pending result overwritten");

endmodule
